// ===== rtl/nec_tx_pkg.sv =====
`timescale 1ns / 1ps

package nec_tx_pkg;

    // payload widths
    localparam int FRAME_WORD_W = 32;
    localparam int TICK_W       = 16;

    // apb register map
    localparam int CFG_COUNT  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    typedef logic [TICK_W-1:0]    t_ticks;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_HDR_PULSE  = 3'd0;
    localparam t_cfg_idx REG_HDR_SPACE  = 3'd1;
    localparam t_cfg_idx REG_ZERO_PULSE = 3'd2;
    localparam t_cfg_idx REG_ZERO_SPACE = 3'd3;
    localparam t_cfg_idx REG_ONE_PULSE  = 3'd4;
    localparam t_cfg_idx REG_ONE_SPACE  = 3'd5;
    localparam t_cfg_idx REG_END_PULSE  = 3'd6;
    localparam t_cfg_idx REG_END_SPACE  = 3'd7;

    // register reset values
    localparam t_ticks RST_HDR_PULSE  = 16'd16;
    localparam t_ticks RST_HDR_SPACE  = 16'd8;
    localparam t_ticks RST_ZERO_PULSE = 16'd1;
    localparam t_ticks RST_ZERO_SPACE = 16'd1;
    localparam t_ticks RST_ONE_PULSE  = 16'd1;
    localparam t_ticks RST_ONE_SPACE  = 16'd3;
    localparam t_ticks RST_END_PULSE  = 16'd1;
    localparam t_ticks RST_END_SPACE  = 16'd0;

    // item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // count down by one, holding at zero
    function automatic t_ticks dec_sat(input t_ticks v);
        dec_sat = (v != '0) ? v - t_ticks'(1) : '0;
    endfunction

endpackage

// ===== rtl/nec_tx_if.sv =====
`timescale 1ns / 1ps

interface nec_tx_in_if
    import nec_tx_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [FRAME_WORD_W-1:0] frame_word;

    modport source (output valid, output opcode, output frame_word, input ready);
    modport sink   (input valid, input opcode, input frame_word, output ready);
endinterface

interface nec_tx_out_if;
    logic valid;
    logic ready;
    logic carrier_on;
    logic busy_res;
    logic frame_done;

    modport source (output valid, output carrier_on, output busy_res, output frame_done,
                    input ready);
    modport sink   (input valid, input carrier_on, input busy_res, input frame_done,
                    output ready);
endinterface

// ===== rtl/nec_ir_frame_transmitter_top.sv =====
`timescale 1ns / 1ps

// nec-style infrared envelope generator. a start transfer (opcode 1) loads a frame
// word while idle; every tick transfer (opcode 0) then advances the envelope by one
// timer tick and returns the line level: header burst, header silence, FRAME_BITS data
// bits msb first (burst, then a silence whose length depends on the bit), stop burst
// and stop silence, with frame_done high on the tick that ends the stop silence. every
// input transfer yields exactly one output transfer. all durations are tick counts in
// eight 16-bit apb registers at byte addresses 0x00..0x1c; writes land on the access
// phase and must only happen while the block is idle. one item is taken per clock: the
// state counters and shift register update in the cycle the item is accepted, and the
// result lands in a single output register, so the input stalls only while that
// register is full and not being taken.

module nec_ir_frame_transmitter_top
    import nec_tx_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    // item channels
    nec_tx_in_if.sink            i_in,
    nec_tx_out_if.source         o_out
);

    localparam int BITS_W = $clog2(FRAME_BITS);
    localparam logic [BITS_W-1:0] LAST_BIT = BITS_W'(FRAME_BITS - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PENDING,
        PH_HEADER,
        PH_DATA,
        PH_END
    } t_phase;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    t_ticks   r_cfg [CFG_COUNT];
    t_cfg_idx w_cfg_idx;
    logic     w_cfg_wr;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = PDATA_W'(r_cfg[w_cfg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_HDR_PULSE]  <= RST_HDR_PULSE;
            r_cfg[REG_HDR_SPACE]  <= RST_HDR_SPACE;
            r_cfg[REG_ZERO_PULSE] <= RST_ZERO_PULSE;
            r_cfg[REG_ZERO_SPACE] <= RST_ZERO_SPACE;
            r_cfg[REG_ONE_PULSE]  <= RST_ONE_PULSE;
            r_cfg[REG_ONE_SPACE]  <= RST_ONE_SPACE;
            r_cfg[REG_END_PULSE]  <= RST_END_PULSE;
            r_cfg[REG_END_SPACE]  <= RST_END_SPACE;
        end else if (w_cfg_wr) begin
            r_cfg[w_cfg_idx] <= pwdata[TICK_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // envelope state
    // ---------------------------------------------------------------
    t_phase                r_phase, n_phase;
    t_ticks                r_pulse_left, n_pulse_left;
    t_ticks                r_space_left, n_space_left;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [BITS_W-1:0]     r_bits_left, n_bits_left;
    logic                  r_level, n_level;
    logic                  n_done;

    // output register
    logic r_out_valid;
    logic r_carrier_on;
    logic r_busy_res;
    logic r_frame_done;

    logic w_accept;
    logic w_bit;

    // input is taken whenever the result register is free or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_bit      = r_shift[FRAME_BITS-1];

    always_comb begin
        n_phase      = r_phase;
        n_pulse_left = r_pulse_left;
        n_space_left = r_space_left;
        n_shift      = r_shift;
        n_bits_left  = r_bits_left;
        n_level      = r_level;
        n_done       = 1'b0;

        if (i_in.opcode == OP_START) begin
            // a start while busy leaves everything as is
            if (r_phase == PH_IDLE) begin
                n_shift      = FRAME_BITS'(i_in.frame_word);
                n_pulse_left = '0;
                n_space_left = '0;
                n_bits_left  = '0;
                n_level      = 1'b0;
                n_phase      = PH_PENDING;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_level = 1'b0;
                end
                PH_PENDING: begin
                    n_pulse_left = r_cfg[REG_HDR_PULSE];
                    n_space_left = r_cfg[REG_HDR_SPACE];
                    n_level      = 1'b0;
                    n_phase      = PH_HEADER;
                end
                PH_HEADER, PH_DATA, PH_END: begin
                    if (r_pulse_left != '0) begin
                        // burst still running
                        n_level      = 1'b1;
                        n_pulse_left = r_pulse_left - t_ticks'(1);
                    end else if (r_space_left != '0) begin
                        // silence still running
                        n_level      = 1'b0;
                        n_space_left = r_space_left - t_ticks'(1);
                    end else if (r_phase == PH_END) begin
                        n_level = 1'b0;
                        n_done  = 1'b1;
                        n_phase = PH_IDLE;
                    end else if (r_phase == PH_HEADER || r_bits_left != '0) begin
                        // start the next data bit from the top of the shift register
                        n_shift = {r_shift[FRAME_BITS-2:0], 1'b0};
                        if (w_bit) begin
                            n_pulse_left = dec_sat(r_cfg[REG_ONE_PULSE]);
                            n_space_left = r_cfg[REG_ONE_SPACE];
                        end else begin
                            n_pulse_left = dec_sat(r_cfg[REG_ZERO_PULSE]);
                            n_space_left = r_cfg[REG_ZERO_SPACE];
                        end
                        n_level     = 1'b1;
                        n_bits_left = (r_phase == PH_HEADER) ? LAST_BIT
                                                             : r_bits_left - BITS_W'(1);
                        n_phase     = PH_DATA;
                    end else begin
                        // last bit done, stop burst
                        n_pulse_left = dec_sat(r_cfg[REG_END_PULSE]);
                        n_space_left = r_cfg[REG_END_SPACE];
                        n_level      = 1'b1;
                        n_phase      = PH_END;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_level = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_pulse_left <= '0;
            r_space_left <= '0;
            r_shift      <= '0;
            r_bits_left  <= '0;
            r_level      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase      <= n_phase;
                r_pulse_left <= n_pulse_left;
                r_space_left <= n_space_left;
                r_shift      <= n_shift;
                r_bits_left  <= n_bits_left;
                r_level      <= n_level;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_carrier_on <= n_level;
            r_busy_res   <= (n_phase != PH_IDLE);
            r_frame_done <= n_done;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.carrier_on = r_carrier_on;
    assign o_out.busy_res   = r_busy_res;
    assign o_out.frame_done = r_frame_done;

endmodule
